FILE: sv/mvm_pkg.sv
// Shared types and constants of the matrix-vector multiplier.
package mvm_pkg;

  localparam int MAX_SIZE_DEF = 1024;
  localparam int SIZE_W       = 11;
  localparam int SIZE_RESET   = 1024;
  localparam int VAL_W        = 16;
  localparam int PROD_W       = 2 * VAL_W;
  localparam int SUM_W        = 48;
  localparam int ROW_W        = 10;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MATRIX = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic signed [VAL_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] row_result;
    logic [ROW_W-1:0]        row_index;
    logic                    last_row;
  } out_item_t;

  typedef struct packed {
    logic             last_col;
    logic             last_row;
    logic [ROW_W-1:0] row_index;
  } tag_t;

endpackage

FILE: sv/mvm_vec_mem.sv
// Vector store: one write port, one registered read port.
module mvm_vec_mem #(
  parameter int DEPTH = mvm_pkg::MAX_SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic signed [mvm_pkg::VAL_W-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic signed [mvm_pkg::VAL_W-1:0] rdata_o
);
  import mvm_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the read data while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mvm_addr_gen.sv
// Position counters: vector load address, column and row of the matrix stream.
module mvm_addr_gen #(
  parameter int MAX_SIZE = mvm_pkg::MAX_SIZE_DEF,
  parameter int AW       = $clog2(MAX_SIZE)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mvm_pkg::SIZE_W-1:0]       cfg_wdata_i,
  input  logic                             accept_i,
  input  mvm_pkg::in_item_t                item_i,
  output logic                             mem_we_o,
  output logic [AW-1:0]                    mem_waddr_o,
  output logic signed [mvm_pkg::VAL_W-1:0] mem_wdata_o,
  output logic [AW-1:0]                    mem_raddr_o,
  output logic                             mat_valid_o,
  output mvm_pkg::tag_t                    mat_tag_o
);
  import mvm_pkg::*;

  localparam int CNT_W   = $clog2(MAX_SIZE + 1);
  localparam int CMP_W   = (SIZE_W > CNT_W) ? SIZE_W : CNT_W;
  localparam int RESET_N = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;
  localparam logic [AW-1:0] LAST_RESET = AW'(RESET_N - 1);

  logic [AW-1:0]    last_q, last_d, cfg_last;
  logic [AW-1:0]    load_q, load_d;
  logic [AW-1:0]    col_q, col_d;
  logic [AW-1:0]    row_q, row_d;
  logic [CMP_W-1:0] size_ext;
  logic             is_load, is_mat, last_col, last_row;

  // saturate the written size to 1..MAX_SIZE and keep size-1
  always_comb begin
    size_ext = CMP_W'(cfg_wdata_i);
    if (size_ext == '0) begin
      cfg_last = '0;
    end else if (size_ext > CMP_W'(MAX_SIZE)) begin
      cfg_last = AW'(MAX_SIZE - 1);
    end else begin
      cfg_last = AW'(size_ext - CMP_W'(1));
    end
  end

  assign is_load  = accept_i && (item_i.opcode == OP_LOAD);
  assign is_mat   = accept_i && (item_i.opcode == OP_MATRIX);
  assign last_col = (col_q == last_q);
  assign last_row = (row_q == last_q);

  always_comb begin
    last_d = last_q;
    load_d = load_q;
    col_d  = col_q;
    row_d  = row_q;
    if (cfg_we_i) begin
      last_d = cfg_last;
      load_d = '0;
      col_d  = '0;
      row_d  = '0;
    end else if (is_load) begin
      load_d = (load_q == last_q) ? '0 : load_q + AW'(1);
    end else if (is_mat) begin
      col_d = last_col ? '0 : col_q + AW'(1);
      if (last_col) begin
        row_d = last_row ? '0 : row_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= LAST_RESET;
      load_q <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      last_q <= last_d;
      load_q <= load_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  assign mem_we_o    = is_load;
  assign mem_waddr_o = load_q;
  assign mem_wdata_o = item_i.element_value;
  assign mem_raddr_o = col_q;

  assign mat_valid_o         = is_mat;
  assign mat_tag_o.last_col  = last_col;
  assign mat_tag_o.last_row  = last_row;
  assign mat_tag_o.row_index = ROW_W'(row_q);

endmodule

FILE: sv/mvm_mac.sv
// Multiply-accumulate pipeline with the result register.
module mvm_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic                             mat_valid_i,
  input  mvm_pkg::tag_t                    mat_tag_i,
  input  logic signed [mvm_pkg::VAL_W-1:0] mat_value_i,
  input  logic signed [mvm_pkg::VAL_W-1:0] vec_value_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output mvm_pkg::out_item_t               out_item_o,
  output logic                             advance_o
);
  import mvm_pkg::*;

  logic                     s1_valid_q, s2_valid_q, out_valid_q, out_valid_d;
  tag_t                     s1_tag_q, s2_tag_q;
  logic signed [VAL_W-1:0]  s1_val_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  acc_q, acc_d, sum;
  out_item_t                out_q;
  logic                     advance, emit;

  // stall only when a row result meets a full, stalled output register
  assign advance = !(out_valid_q && out_stall_i) || !(s2_valid_q && s2_tag_q.last_col);
  assign emit    = advance && s2_valid_q && s2_tag_q.last_col;
  assign sum     = acc_q + {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (advance && s2_valid_q) begin
      acc_d = s2_tag_q.last_col ? '0 : sum;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (advance) begin
        s1_valid_q <= mat_valid_i;
        s2_valid_q <= s1_valid_q;
      end
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_tag_q <= mat_tag_i;
      s1_val_q <= mat_value_i;
      s2_tag_q <= s1_tag_q;
      prod_q   <= s1_val_q * vec_value_i;
    end
    if (emit) begin
      out_q.row_result <= sum;
      out_q.row_index  <= s2_tag_q.row_index;
      out_q.last_row   <= s2_tag_q.last_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign advance_o   = advance;

endmodule

FILE: sv/matrix_vector_multiply.sv
// Top level of the streamed dense matrix-vector multiplier.
// A row result is registered after its last matrix item passes stages s1 and s2.
// Throughput: one item per cycle, set by one vector-store read and one MAC per item.
// The input stalls only while a row result meets a full, stalled output register.
// Reset clears counters and the running sum, and sets size to min(1024, MAX_SIZE).
// The vector store is not cleared: each entry must be loaded before it is used.
module matrix_vector_multiply #(
  parameter int MAX_SIZE = mvm_pkg::MAX_SIZE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mvm_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mvm_pkg::out_item_t         out_item_o,
  input  logic                       cfg_we_i,
  input  logic [mvm_pkg::SIZE_W-1:0] cfg_wdata_i
);
  import mvm_pkg::*;

  localparam int AW = $clog2(MAX_SIZE);

  logic                    advance, accept;
  logic                    mem_we, mat_valid;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic signed [VAL_W-1:0] mem_wdata, vec_value;
  tag_t                    mat_tag;

  // an item enters whenever the MAC pipeline moves
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  // counters: pick the load slot, or the column to read for a matrix item
  mvm_addr_gen #(
    .MAX_SIZE (MAX_SIZE),
    .AW       (AW)
  ) u_addr_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mat_valid_o (mat_valid),
    .mat_tag_o   (mat_tag)
  );

  // a load of an entry is always taken in an earlier cycle than its read,
  // so the write has landed before any read of that entry
  mvm_vec_mem #(
    .DEPTH (MAX_SIZE),
    .AW    (AW)
  ) u_vec_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (advance),
    .raddr_i (mem_raddr),
    .rdata_o (vec_value)
  );

  // multiply, accumulate over the row, and hold the row result;
  // the MAC registers the element alongside the vector read
  mvm_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_we_i),
    .mat_valid_i (mat_valid),
    .mat_tag_i   (mat_tag),
    .mat_value_i (in_item_i.element_value),
    .vec_value_i (vec_value),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .advance_o   (advance)
  );

endmodule

FILE: sv/mvm_checker.sv
// Port-level checker for the matrix-vector multiplier, with its bind.
module mvm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mvm_pkg::out_item_t out_item_o
);
  import mvm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result item changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a full, stalled output");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("activity during reset");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
